// ----- rtl/core/bearing_elevation_distance_3d_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bearing/elevation/distance block
// Clocked, reset-qualified concurrent checks used by the RTL.
// ----------------------------------------------------------------------------
`ifndef BEARING_ELEVATION_DISTANCE_3D_ASSERT_SVH
`define BEARING_ELEVATION_DISTANCE_3D_ASSERT_SVH

// Check a property at every rising clk edge outside reset.
`define BED3D_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define BED3D_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ----- rtl/core/bed3d_pkg.sv -----
// ----------------------------------------------------------------------------
// bed3d_pkg
// Widths, constants and the arctangent table shared by the 3D converter.
// ----------------------------------------------------------------------------
package bed3d_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int CORDIC_STAGES = 16;

  // Difference, square and sum widths
  localparam int D_W  = COORD_WIDTH + 1;
  localparam int SQ_W = 2 * COORD_WIDTH;
  localparam int H_W  = SQ_W + 1;
  localparam int S_W  = SQ_W + 2;

  // Square root: radicand holds h * 4096 and s * 256
  localparam int RAD_W  = ((H_W + 13) / 2) * 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 1;

  // CORDIC datapath: vector and angle (2^-30 rad) widths
  localparam int CX_W = D_W + 11;
  localparam int CZ_W = 34;
  localparam int PZ_W = CZ_W + 2;

  // Output fields
  localparam int BEAR_W = 16;
  localparam int ELEV_W = 15;
  localparam int DIST_W = 29;

  localparam int IN_TDATA_W  = ((6 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((BEAR_W + ELEV_W + DIST_W + 7) / 8) * 8;

  localparam int BEAR_MAX    = 25736;
  localparam int ELEV_MAX    = 12868;
  localparam int HALF_PI_Q13 = 12868;

  localparam logic signed [PZ_W-1:0] PI_Q30   = PZ_W'(64'sd3373259426);
  localparam int                     Q13_RND  = 65536;
  localparam int                     Q13_SHFT = 17;

  // atan(2^-i) in units of 2^-30 rad
  function automatic logic signed [CZ_W-1:0] atan_q30(input int i);
    logic signed [CZ_W-1:0] v;
    case (i)
      0:       v = CZ_W'(843314857);
      1:       v = CZ_W'(497837829);
      2:       v = CZ_W'(263043837);
      3:       v = CZ_W'(133525159);
      4:       v = CZ_W'(67021687);
      5:       v = CZ_W'(33543516);
      6:       v = CZ_W'(16775851);
      7:       v = CZ_W'(8388437);
      8:       v = CZ_W'(4194283);
      9:       v = CZ_W'(2097149);
      10:      v = CZ_W'(1048576);
      11:      v = CZ_W'(524288);
      12:      v = CZ_W'(262144);
      13:      v = CZ_W'(131072);
      14:      v = CZ_W'(65536);
      15:      v = CZ_W'(32768);
      16:      v = CZ_W'(16384);
      17:      v = CZ_W'(8192);
      18:      v = CZ_W'(4096);
      19:      v = CZ_W'(2048);
      20:      v = CZ_W'(1024);
      21:      v = CZ_W'(512);
      22:      v = CZ_W'(256);
      23:      v = CZ_W'(128);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/bed3d_isqrt.sv -----
// ----------------------------------------------------------------------------
// bed3d_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module bed3d_isqrt import bed3d_pkg::*; (
  input  logic              clk,
  input  logic              ce,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root,
  output logic [REM_W-1:0]  rem
);

  logic [ROOT_W-1:0] qr [ROOT_W];
  logic [RAD_W-1:0]  rr [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    localparam int K = ROOT_W - 1 - g;
    logic [ROOT_W-1:0] qi;
    logic [RAD_W-1:0]  ri;
    logic [RAD_W:0]    trial;

    if (g == 0) begin : g_first
      assign qi = '0;
      assign ri = rad;
    end else begin : g_next
      assign qi = qr[g-1];
      assign ri = rr[g-1];
    end

    // (2q + 2^k) * 2^k: the low term never overlaps the shifted root
    assign trial = ((RAD_W+1)'(qi) << (K + 1)) | ((RAD_W+1)'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (ce) begin
        if ({1'b0, ri} >= trial) begin
          rr[g] <= ri - trial[RAD_W-1:0];
          qr[g] <= qi | (ROOT_W'(1) << K);
        end else begin
          rr[g] <= ri;
          qr[g] <= qi;
        end
      end
    end
  end

  assign root = qr[ROOT_W-1];
  assign rem  = rr[ROOT_W-1][REM_W-1:0];

endmodule

// ----- rtl/core/bed3d_cordic.sv -----
// ----------------------------------------------------------------------------
// bed3d_cordic
// Pipelined CORDIC vectoring, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module bed3d_cordic import bed3d_pkg::*; (
  input  logic                   clk,
  input  logic                   ce,
  input  logic signed [CX_W-1:0] x_in,
  input  logic signed [CX_W-1:0] y_in,
  output logic signed [CZ_W-1:0] z_out
);

  logic signed [CX_W-1:0] xr [CORDIC_STAGES];
  logic signed [CX_W-1:0] yr [CORDIC_STAGES];
  logic signed [CZ_W-1:0] zr [CORDIC_STAGES];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    logic signed [CX_W-1:0] xi, yi;
    logic signed [CZ_W-1:0] zi;

    if (g == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = '0;
    end else begin : g_next
      assign xi = xr[g-1];
      assign yi = yr[g-1];
      assign zi = zr[g-1];
    end

    // Rotate toward the x axis; direction from the sign of y
    always_ff @(posedge clk) begin
      if (ce) begin
        if (!yi[CX_W-1]) begin
          xr[g] <= xi + (yi >>> g);
          yr[g] <= yi - (xi >>> g);
          zr[g] <= zi + atan_q30(g);
        end else begin
          xr[g] <= xi - (yi >>> g);
          yr[g] <= yi + (xi >>> g);
          zr[g] <= zi - atan_q30(g);
        end
      end
    end
  end

  assign z_out = zr[CORDIC_STAGES-1];

endmodule

// ----- rtl/core/bearing_elevation_distance_3d.sv -----
// ----------------------------------------------------------------------------
// bearing_elevation_distance_3d
// Converts a point pair to bearing, elevation and distance of the vector
// between them.
// ----------------------------------------------------------------------------
// The block accepts one point pair per cycle while the output item is taken
// and returns one item per pair. The difference, square and sum registers
// come first, a 31-stage square-root pipeline then produces the horizontal
// radius and the distance, and the elevation CORDIC (16 stages) runs on that
// radius before the output register. The bearing CORDIC runs beside the root
// pipeline. The whole pipeline advances as one; when the output item is
// not taken, every stage holds and no item is lost or repeated. Angles are
// radians with 13 fraction bits (bearing Q3.13, elevation Q2.13), the
// distance carries 4 fraction bits and is rounded to nearest.
// ----------------------------------------------------------------------------
`include "bearing_elevation_distance_3d_assert.svh"

module bearing_elevation_distance_3d import bed3d_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // from_x, from_y, from_z, to_x, to_y, to_z (COORD_WIDTH each, lowest first)
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // bearing [15:0], elevation [30:16], distance [59:31], zero padding above
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int LAST = 2 + ROOT_W + CORDIC_STAGES;

  typedef struct packed {
    logic                     use_cordic;
    logic                     neg;
    logic                     dy_neg;
    logic signed [BEAR_W-1:0] spec;
  } bear_side_t;

  typedef struct packed {
    logic                     use_cordic;
    logic signed [ELEV_W-1:0] spec;
  } elev_side_t;

  logic        adv;
  logic [LAST:0] vld;

  // Advance the whole pipeline whenever the output register is free
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[LAST-1:0], s_tvalid};
      m_tvalid <= vld[LAST];
    end
  end

  // ---------------- stage 1: difference vector ----------------
  logic signed [COORD_WIDTH-1:0] fx, fy, fz, tx, ty, tz;
  logic signed [D_W-1:0]         dx1, dy1, dz1;

  assign fx = s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
  assign fy = s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
  assign fz = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
  assign tx = s_tdata[3*COORD_WIDTH +: COORD_WIDTH];
  assign ty = s_tdata[4*COORD_WIDTH +: COORD_WIDTH];
  assign tz = s_tdata[5*COORD_WIDTH +: COORD_WIDTH];

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1 <= D_W'(tx) - D_W'(fx);
      dy1 <= D_W'(ty) - D_W'(fy);
      dz1 <= D_W'(tz) - D_W'(fz);
    end
  end

  // ---------------- stage 2: squares ----------------
  logic signed [2*D_W-1:0] px, py, pz;
  logic [SQ_W-1:0]         xx2, yy2, zz2;
  logic signed [D_W-1:0]   dx2, dy2, dz2;

  assign px = dx1 * dx1;
  assign py = dy1 * dy1;
  assign pz = dz1 * dz1;

  always_ff @(posedge clk) begin
    if (adv) begin
      xx2 <= px[SQ_W-1:0];
      yy2 <= py[SQ_W-1:0];
      zz2 <= pz[SQ_W-1:0];
      dx2 <= dx1;
      dy2 <= dy1;
      dz2 <= dz1;
    end
  end

  // ---------------- stage 3: sums and CORDIC setup ----------------
  logic [H_W-1:0]         h3;
  logic [S_W-1:0]         s3;
  logic signed [D_W-1:0]  dz3;
  logic signed [CX_W-1:0] bx3, by3, dxw, dyw;
  bear_side_t             bside3, bside_n;
  elev_side_t             eside3, eside_n;
  logic                   dx_zero, dy_zero;

  assign dxw     = CX_W'(dx2);
  assign dyw     = CX_W'(dy2);
  assign dx_zero = (dx2 == '0);
  assign dy_zero = (dy2 == '0);

  always_comb begin
    // Bearing: fold the left half-plane into the right one
    bside_n.neg        = dx2[D_W-1];
    bside_n.dy_neg     = dy2[D_W-1];
    bside_n.use_cordic = !dx_zero && !dy_zero;
    if (dy_zero) begin
      bside_n.spec = dx2[D_W-1] ? BEAR_W'(BEAR_MAX) : '0;
    end else if (dy2[D_W-1]) begin
      bside_n.spec = -BEAR_W'(HALF_PI_Q13);
    end else begin
      bside_n.spec = BEAR_W'(HALF_PI_Q13);
    end
    // Elevation: flat and vertical vectors bypass the CORDIC
    eside_n.use_cordic = (dz2 != '0) && !(dx_zero && dy_zero);
    if (dz2 == '0) begin
      eside_n.spec = '0;
    end else if (dz2[D_W-1]) begin
      eside_n.spec = -ELEV_W'(ELEV_MAX);
    end else begin
      eside_n.spec = ELEV_W'(ELEV_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h3     <= H_W'(xx2) + H_W'(yy2);
      s3     <= S_W'(xx2) + S_W'(yy2) + S_W'(zz2);
      bx3    <= (dx2[D_W-1] ? -dxw : dxw) <<< 8;
      by3    <= (dx2[D_W-1] ? -dyw : dyw) <<< 8;
      bside3 <= bside_n;
      eside3 <= eside_n;
      dz3    <= dz2;
    end
  end

  // ---------------- square roots ----------------
  logic [ROOT_W-1:0] hr, sr;
  logic [REM_W-1:0]  hrem, srem;

  bed3d_isqrt u_sqrt_h (
    .clk  (clk),
    .ce   (adv),
    .rad  (RAD_W'(h3) << 12),
    .root (hr),
    .rem  (hrem)
  );

  bed3d_isqrt u_sqrt_s (
    .clk  (clk),
    .ce   (adv),
    .rad  (RAD_W'(s3) << 8),
    .root (sr),
    .rem  (srem)
  );

  // ---------------- bearing CORDIC ----------------
  logic signed [CZ_W-1:0] bz;
  bear_side_t             bside_d [CORDIC_STAGES];

  bed3d_cordic u_cordic_bear (
    .clk   (clk),
    .ce    (adv),
    .x_in  (bx3),
    .y_in  (by3),
    .z_out (bz)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      bside_d[0] <= bside3;
      for (int i = 1; i < CORDIC_STAGES; i++) begin
        bside_d[i] <= bside_d[i-1];
      end
    end
  end

  // Add back +-pi for the folded half-plane, round to Q3.13 and clamp
  bear_side_t               bs;
  logic signed [PZ_W-1:0]   boff, bzadj, bq;
  logic signed [BEAR_W-1:0] bfin;
  logic signed [BEAR_W-1:0] bear_d [ROOT_W];

  assign bs = bside_d[CORDIC_STAGES-1];

  always_comb begin
    if (!bs.neg) begin
      boff = PZ_W'(Q13_RND);
    end else if (bs.dy_neg) begin
      boff = PZ_W'(Q13_RND) - PI_Q30;
    end else begin
      boff = PZ_W'(Q13_RND) + PI_Q30;
    end
    bzadj = PZ_W'(bz) + boff;
    bq    = bzadj >>> Q13_SHFT;
    if (!bs.use_cordic) begin
      bfin = bs.spec;
    end else if (bq > PZ_W'(BEAR_MAX)) begin
      bfin = BEAR_W'(BEAR_MAX);
    end else if (bq < -PZ_W'(BEAR_MAX)) begin
      bfin = -BEAR_W'(BEAR_MAX);
    end else begin
      bfin = bq[BEAR_W-1:0];
    end
  end

  // Hold the bearing until the elevation catches up
  always_ff @(posedge clk) begin
    if (adv) begin
      bear_d[0] <= bfin;
      for (int i = 1; i < ROOT_W; i++) begin
        bear_d[i] <= bear_d[i-1];
      end
    end
  end

  // ---------------- elevation CORDIC ----------------
  logic signed [D_W-1:0] dz_d    [ROOT_W];
  elev_side_t            eside_d [ROOT_W];
  elev_side_t            eside_e [CORDIC_STAGES];
  logic signed [CZ_W-1:0] ez;

  always_ff @(posedge clk) begin
    if (adv) begin
      dz_d[0]    <= dz3;
      eside_d[0] <= eside3;
      for (int i = 1; i < ROOT_W; i++) begin
        dz_d[i]    <= dz_d[i-1];
        eside_d[i] <= eside_d[i-1];
      end
      eside_e[0] <= eside_d[ROOT_W-1];
      for (int i = 1; i < CORDIC_STAGES; i++) begin
        eside_e[i] <= eside_e[i-1];
      end
    end
  end

  bed3d_cordic u_cordic_elev (
    .clk   (clk),
    .ce    (adv),
    .x_in  (CX_W'(hr)),
    .y_in  (CX_W'(dz_d[ROOT_W-1]) <<< 6),
    .z_out (ez)
  );

  elev_side_t               es;
  logic signed [CZ_W:0]     ezadj, eq;
  logic signed [ELEV_W-1:0] efin;

  assign es    = eside_e[CORDIC_STAGES-1];
  assign ezadj = (CZ_W+1)'(ez) + (CZ_W+1)'(Q13_RND);
  assign eq    = ezadj >>> Q13_SHFT;

  always_comb begin
    if (!es.use_cordic) begin
      efin = es.spec;
    end else if (eq > (CZ_W+1)'(ELEV_MAX)) begin
      efin = ELEV_W'(ELEV_MAX);
    end else if (eq < -(CZ_W+1)'(ELEV_MAX)) begin
      efin = -ELEV_W'(ELEV_MAX);
    end else begin
      efin = eq[ELEV_W-1:0];
    end
  end

  // ---------------- distance rounding ----------------
  logic [ROOT_W:0]     dsum;
  logic [DIST_W-1:0]   dist_d [CORDIC_STAGES];

  // Round up when the remainder exceeds the root
  assign dsum = (ROOT_W+1)'(sr) + (ROOT_W+1)'(srem > REM_W'(sr));

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_d[0] <= dsum[DIST_W-1:0];
      for (int i = 1; i < CORDIC_STAGES; i++) begin
        dist_d[i] <= dist_d[i-1];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {(OUT_TDATA_W-BEAR_W-ELEV_W-DIST_W)'(0),
                  dist_d[CORDIC_STAGES-1], efin, bear_d[ROOT_W-1]};
    end
  end

  // ---------------- checks ----------------
  `BED3D_ASSERT_NEXT(a_in_enters, s_tvalid && s_tready, vld[0], "accepted item not in pipeline")
  `BED3D_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld) && $stable(m_tvalid), "pipeline moved on stall")
  `BED3D_ASSERT(a_bear_range, m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736 && $signed(m_tdata[15:0]) >= -16'sd25736), "bearing out of range")
  `BED3D_ASSERT(a_elev_range, m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd12868 && $signed(m_tdata[30:16]) >= -15'sd12868), "elevation out of range")

endmodule
